### sv/bisc_pkg.sv
// Shared types, codes and constants of the binary image bilinear scaler.
package bisc_pkg;

  localparam int SLOTS     = 4;
  localparam int SLOT_W    = 2;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 10;
  localparam int CFG_W     = 26;
  localparam int DIM_W     = 11;
  localparam int FRAC      = 16;
  localparam int MEM_AW    = SLOT_W + COL_W;
  localparam int PROD_W    = CFG_W + COL_W;
  localparam int WGT_W     = FRAC + 1;
  localparam int SUM_W     = 2 * FRAC + 1;
  localparam int GRAY      = 180;
  localparam int MAX_OUT   = 1024;

  // Command codes
  localparam logic [1:0] CMD_FEED    = 2'd0;
  localparam logic [1:0] CMD_PRODUCE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_IN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH = 3'd2;
  localparam logic [2:0] REG_X_STEP    = 3'd3;
  localparam logic [2:0] REG_Y_STEP    = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic feed;
    logic ymul;
    logic look;
    logic ld_query;
    logic ld_miss;
    logic ld_zero;
    logic jclr;
    logic xmul;
    logic rd0;
    logic rd1;
    logic wmul;
    logic sum;
    logic cmp;
  } bisc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       hit_both;
    logic       w_zero;
    logic       word_end;
    logic       row_end;
  } bisc_stat_t;

endpackage

### sv/binary_image_bilinear_scaler_unit.sv
// Top level of the binary image bilinear scaler.
// Feed and query: one request at a time; in_tready is high only while idle.
// Produce: row lookup (S_YMUL, S_LOOK, S_CHK), then per output pixel S_XMUL, S_RD0,
// S_RD1, S_WMUL, S_SUM and S_CMP, plus S_OUT for each word handed over.
// Reset (synchronous, rst_n low) empties the row cache and restores register defaults;
// pixel storage is not cleared.
module binary_image_bilinear_scaler_unit import bisc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // cmd[1:0], col[11:2], row[21:12], pixel[22]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,  // status[1:0], ready_res[2], word_index[6:3],
                                        // out_bits[70:7]
  output logic              out_tlast
);

  bisc_cmd_t  cmd;
  bisc_stat_t stat;

  bisc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bisc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

### sv/bisc_dp.sv
// Datapath: configuration, row cache, pixel store, interpolation and result register.
module bisc_dp import bisc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [23:0]       in_tdata,
  input  bisc_cmd_t         cmd,
  output bisc_stat_t        stat,
  output logic [71:0]       out_tdata,
  output logic              out_tlast
);

  logic [DIM_W-1:0]  in_width_r, in_height_r, out_width_r;
  logic [CFG_W-1:0]  x_step_r, y_step_r;
  logic [SLOTS-1:0]  used_r;
  logic [ROW_W-1:0]  tag_r [SLOTS];
  logic [1:0]        cmd_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              pix_r;
  logic [PROD_W-1:0] p_r, q_r;
  logic              hit0_r, hit1_r;
  logic [SLOT_W-1:0] s0_r, s1_r;
  logic [9:0]        j_r;
  logic [63:0]       bits_r;
  logic              a_r, c_r;
  logic [2*WGT_W-1:0] pa_r, pb_r;
  logic [SUM_W-1:0]  s_r;
  logic              mem [1 << MEM_AW];
  logic              rd0_q, rd1_q;
  logic [1:0]        o_status_r;
  logic              o_ready_r;
  logic [3:0]        o_widx_r;
  logic [63:0]       o_bits_r;
  logic              o_last_r;

  // Slot claim for a feed
  logic [SLOT_W-1:0] pick, lowpick, slot;
  logic              found;
  logic [ROW_W-1:0]  low;
  always_comb begin
    pick = '0;
    lowpick = '0;
    found = 1'b0;
    low = '1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found) begin
        if (!used_r[i]) begin
          pick = SLOT_W'(i);
          found = 1'b1;
        end else if (tag_r[i] == row_r) begin
          pick = SLOT_W'(i);
          found = 1'b1;
        end else if (tag_r[i] <= low) begin
          low = tag_r[i];
          lowpick = SLOT_W'(i);
        end
      end
    end
    slot = found ? pick : lowpick;
  end

  logic feed_ok;
  assign feed_ok = ({1'b0, col_r} < in_width_r) && ({1'b0, row_r} < in_height_r);

  // Cache lookup of rows y and y+1
  logic [19:0] y;
  logic [20:0] y1;
  logic        h0, h1;
  logic [SLOT_W-1:0] hs0, hs1;
  assign y  = p_r[PROD_W-1:FRAC];
  assign y1 = {1'b0, y} + 21'd1;
  always_comb begin
    h0 = 1'b0;
    h1 = 1'b0;
    hs0 = '0;
    hs1 = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && y[19:10] == 10'd0 && tag_r[i] == y[9:0]) begin
        h0 = 1'b1;
        hs0 = SLOT_W'(i);
      end
      if (used_r[i] && y1[20:10] == 11'd0 && tag_r[i] == y1[9:0]) begin
        h1 = 1'b1;
        hs1 = SLOT_W'(i);
      end
    end
  end

  // Output width and word bounds
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] j_inc;
  assign w = (out_width_r > DIM_W'(MAX_OUT)) ? DIM_W'(MAX_OUT) : out_width_r;
  assign j_inc = {1'b0, j_r} + DIM_W'(1);

  assign stat.cmd      = cmd_r;
  assign stat.hit_both = hit0_r && hit1_r;
  assign stat.w_zero   = (w == '0);
  assign stat.row_end  = (j_inc == w);
  assign stat.word_end = (j_inc == w) || (j_r[5:0] == 6'd63);

  // Source column and its neighbour
  logic [19:0] x;
  logic [20:0] x1;
  logic        x_ok, x1_ok;
  logic [COL_W-1:0] rcol;
  assign x     = q_r[PROD_W-1:FRAC];
  assign x1    = {1'b0, x} + 21'd1;
  assign x_ok  = (x[19:10] == 10'd0) && ({1'b0, x[9:0]} < in_width_r);
  assign x1_ok = (x1[20:10] == 11'd0) && ({1'b0, x1[9:0]} < in_width_r);
  assign rcol  = cmd.rd1 ? x1[9:0] : x[9:0];

  // Weights
  logic [WGT_W-1:0] wx, wy, omx, omy, top, bot;
  logic             b, d;
  assign wx  = {1'b0, q_r[FRAC-1:0]};
  assign wy  = {1'b0, p_r[FRAC-1:0]};
  assign omx = WGT_W'(1 << FRAC) - wx;
  assign omy = WGT_W'(1 << FRAC) - wy;
  assign b   = rd0_q & x1_ok;
  assign d   = rd1_q & x1_ok;
  assign top = (a_r ? omx : '0) + (b ? wx : '0);
  assign bot = (c_r ? omx : '0) + (d ? wx : '0);

  // Threshold test: 255 * sum against 180 in the upper part
  logic [SUM_W+7:0] scaled;
  logic             bitv;
  logic [63:0]      newbits;
  assign scaled  = {s_r, 8'd0} - {8'd0, s_r};
  assign bitv    = scaled >= ((SUM_W+8)'(GRAY) << (2 * FRAC));
  assign newbits = bits_r | (64'(bitv) << j_r[5:0]);

  // Pixel store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.feed && feed_ok) begin
      mem[{slot, col_r}] <= pix_r;
    end
    rd0_q <= mem[{s0_r, rcol}];
    rd1_q <= mem[{s1_r, rcol}];
  end

  // Configuration and cache tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= DIM_W'(1024);
      in_height_r <= DIM_W'(1024);
      out_width_r <= DIM_W'(1024);
      x_step_r    <= CFG_W'(65472);
      y_step_r    <= CFG_W'(65472);
      used_r      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_IN_WIDTH:  in_width_r  <= cfg_wdata[DIM_W-1:0];
          REG_IN_HEIGHT: in_height_r <= cfg_wdata[DIM_W-1:0];
          REG_OUT_WIDTH: out_width_r <= cfg_wdata[DIM_W-1:0];
          REG_X_STEP:    x_step_r    <= cfg_wdata;
          REG_Y_STEP:    y_step_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.feed) begin
        used_r[slot] <= 1'b1;
        tag_r[slot]  <= row_r;
      end
    end
  end

  // Working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_r <= in_tdata[1:0];
      col_r <= in_tdata[11:2];
      row_r <= in_tdata[21:12];
      pix_r <= in_tdata[22];
    end
    if (cmd.ymul) p_r <= y_step_r * PROD_W'(row_r);
    if (cmd.look) begin
      hit0_r <= h0;
      hit1_r <= h1;
      s0_r   <= hs0;
      s1_r   <= hs1;
    end
    if (cmd.jclr) begin
      j_r    <= '0;
      bits_r <= '0;
    end
    if (cmd.xmul) q_r <= x_step_r * PROD_W'(j_r);
    if (cmd.rd1) begin
      a_r <= rd0_q & x_ok;
      c_r <= rd1_q & x_ok;
    end
    if (cmd.wmul) begin
      pa_r <= top * omy;
      pb_r <= bot * wy;
    end
    if (cmd.sum) s_r <= SUM_W'(pa_r) + SUM_W'(pb_r);
    if (cmd.cmp) begin
      j_r <= j_inc[9:0];
      if (stat.word_end) begin
        bits_r     <= '0;
        o_status_r <= ST_OK;
        o_ready_r  <= 1'b0;
        o_widx_r   <= j_r[9:6];
        o_bits_r   <= newbits;
        o_last_r   <= stat.row_end;
      end else begin
        bits_r <= newbits;
      end
    end
    if (cmd.feed || cmd.ld_query || cmd.ld_miss || cmd.ld_zero) begin
      o_status_r <= cmd.feed ? (feed_ok ? ST_OK : ST_RANGE) :
                    (cmd.ld_miss ? ST_MISS : ST_OK);
      o_ready_r  <= cmd.ld_query & hit0_r;
      o_widx_r   <= '0;
      o_bits_r   <= '0;
      o_last_r   <= 1'b1;
    end
  end

  assign out_tdata = {1'b0, o_bits_r, o_widx_r, o_ready_r, o_status_r};
  assign out_tlast = o_last_r;

endmodule

### sv/bisc_ctrl.sv
// Controller: sequences feeds, queries and output row generation.
module bisc_ctrl import bisc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  bisc_stat_t stat,
  output bisc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_YMUL, S_LOOK, S_CHK, S_XMUL, S_RD0, S_RD1, S_WMUL,
    S_SUM, S_CMP, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.cmd)
          CMD_FEED: begin
            cmd.feed  = 1'b1;
            fin_nxt   = 1'b1;
            state_nxt = S_OUT;
          end
          CMD_PRODUCE, CMD_QUERY: state_nxt = S_YMUL;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_YMUL: begin
        cmd.ymul  = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        fin_nxt = 1'b1;
        if (stat.cmd == CMD_QUERY) begin
          cmd.ld_query = 1'b1;
          state_nxt    = S_OUT;
        end else if (!stat.hit_both) begin
          cmd.ld_miss = 1'b1;
          state_nxt   = S_OUT;
        end else if (stat.w_zero) begin
          cmd.ld_zero = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.jclr  = 1'b1;
          fin_nxt   = 1'b0;
          state_nxt = S_XMUL;
        end
      end
      S_XMUL: begin
        cmd.xmul  = 1'b1;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_WMUL;
      end
      S_WMUL: begin
        cmd.wmul  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.word_end) begin
          fin_nxt   = stat.row_end;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_XMUL;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = fin_r ? S_IDLE : S_XMUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule
